/* rtl/core/srb_pkg.sv */
package srb_pkg;

    // field widths of one beat
    localparam int SEQ_W   = 8;
    localparam int SRC_W   = 7;
    localparam int PAY_W   = 16;
    localparam int KIND_W  = 3;
    localparam int STORE_W = SRC_W + PAY_W;

    // defaults for the top level parameters
    localparam int DEF_WINDOW   = 16;
    localparam int DEF_SEQ_BITS = 8;

    // longest burst of results one arrival may cause
    localparam int MAX_RESULTS = 16;

    // result codes
    typedef enum logic [KIND_W-1:0] {
        K_RELEASED  = 3'd0,
        K_HELD      = 3'd1,
        K_NOT_ARMED = 3'd2,
        K_BEYOND    = 3'd3,
        K_DUPLICATE = 3'd4,
        K_INIT      = 3'd5
    } t_kind;

endpackage

/* rtl/core/srb_if.sv */
// input channel: one message or init beat
interface srb_in_if import srb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             func;
    logic [SEQ_W-1:0] seq;
    logic [SRC_W-1:0] source_id;
    logic [PAY_W-1:0] payload_tag;

    modport source (output valid, func, seq, source_id, payload_tag, input ready);
    modport sink   (input valid, func, seq, source_id, payload_tag, output ready);
endinterface

// output channel: one result beat
interface srb_out_if import srb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  out_seq;
    logic [SRC_W-1:0]  out_source;
    logic [PAY_W-1:0]  out_payload;
    logic              last;

    modport source (output valid, kind, out_seq, out_source, out_payload, last, input ready);
    modport sink   (input valid, kind, out_seq, out_source, out_payload, last, output ready);
endinterface

/* rtl/core/srb_ram.sv */
module srb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/sequence_reorder_buffer.sv */
// Resequencer for messages carrying a SEQ_BITS-bit sequence number.
// i_in carries message beats (func low) and init beats (func high); o_out
// carries result beats, the final beat caused by one input having last set.
// An init beat loads the last delivered number, clears all held slots and
// arms the block; messages seen before that come back as not armed.
// A message one past the last delivered is released, followed by its held
// successors in order, MAX_RESULTS beats at most; messages up to WINDOW
// ahead are parked in a slot RAM indexed by sequence modulo WINDOW, others
// come back as duplicate or beyond. An input beat is taken in S_IDLE and
// evaluated in S_EVAL once the output register is free; a release run then
// passes through S_RUN, one slot RAM read per released entry.
// An init beat passes through S_MOD, where the slot of the loaded number is
// found by a reciprocal multiply and one correcting subtract.
// Results leave through an output register; while the receiver stalls, the
// pending result is held, evaluation waits and at most one further input
// beat is taken before the input goes not ready.
// Reset (synchronous, active low) leaves the block disarmed, all slots empty,
// last delivered at one; no clearing pass is needed.
module sequence_reorder_buffer import srb_pkg::*; #(
    parameter int WINDOW   = DEF_WINDOW,
    parameter int SEQ_BITS = DEF_SEQ_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    srb_in_if.sink    i_in,
    srb_out_if.source o_out
);

    localparam int SB   = $clog2(WINDOW);
    localparam int CW   = ((SEQ_BITS > SB) ? SEQ_BITS : SB) + 2;
    localparam int CNTW = $clog2(MAX_RESULTS + 1);
    localparam logic [CW-1:0] SEQ_MOD = CW'(2 ** SEQ_BITS);
    localparam logic [CW-1:0] WIN_C   = CW'(WINDOW);
    localparam logic [SEQ_BITS-1:0] RECIP_C = SEQ_BITS'((2 ** SEQ_BITS) / WINDOW);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_RUN  = 4'b0100,
        S_MOD  = 4'b1000
    } t_state;

    // slot of the number after last, given the slot of last
    function automatic logic [SB-1:0] slot_inc(input logic [SEQ_BITS-1:0] last,
                                               input logic [SB-1:0] slot);
        logic [SEQ_BITS-1:0] nx;
        nx = last + SEQ_BITS'(1);
        if (nx == '0) begin
            return '0;
        end else if (slot == SB'(WINDOW - 1)) begin
            return '0;
        end else begin
            return slot + SB'(1);
        end
    endfunction

    t_state              r_state, n_state;
    logic                r_armed, n_armed;
    logic [SEQ_BITS-1:0] r_last, n_last;
    logic [SB-1:0]       r_slot, n_slot;
    logic [WINDOW-1:0]   r_occ, n_occ;
    logic [CNTW-1:0]     r_cnt, n_cnt;

    logic             r_in_func;
    logic [SEQ_W-1:0] r_in_seq;
    logic [SRC_W-1:0] r_in_src;
    logic [PAY_W-1:0] r_in_pay;

    logic              r_ov;
    logic [KIND_W-1:0] r_okind;
    logic [SEQ_W-1:0]  r_oseq;
    logic [SRC_W-1:0]  r_osrc;
    logic [PAY_W-1:0]  r_opay;
    logic              r_olast;

    logic              load_out;
    t_kind             o_kind;
    logic [SEQ_W-1:0]  o_seq;
    logic [SRC_W-1:0]  o_src;
    logic [PAY_W-1:0]  o_pay;
    logic              o_last;

    logic                in_acc, out_free;
    logic [SEQ_BITS-1:0] sq, d, run_nx;
    logic [CW-1:0]       d_c, sum_c, red_c;
    logic                wrap, in_win, recent;
    logic [SB-1:0]       ev_slot, ev_next, run_slot, run_next;

    logic [2*SEQ_BITS-1:0] mod_prod;
    logic [SEQ_BITS-1:0]   mod_q;
    logic [CW-1:0]         mod_est, mod_rem;

    logic                ram_we;
    logic [SB-1:0]       ram_raddr;
    logic [STORE_W-1:0]  ram_rdata;

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign out_free   = !r_ov || o_out.ready;

    // distance and slot of the captured message
    assign sq      = SEQ_BITS'(r_in_seq);
    assign d       = sq - r_last;
    assign d_c     = CW'(d);
    assign sum_c   = CW'(r_slot) + d_c;
    assign red_c   = (sum_c >= WIN_C) ? (sum_c - WIN_C) : sum_c;
    assign wrap    = (CW'(r_last) + d_c) >= SEQ_MOD;
    assign ev_slot = wrap ? SB'(sq) : SB'(red_c);
    assign ev_next = slot_inc(sq, ev_slot);
    assign in_win  = (d_c >= CW'(2)) && (d_c <= WIN_C);
    assign recent  = (d == '0) || ((d_c + WIN_C) >= SEQ_MOD);

    // successors during a release run
    assign run_nx   = r_last + SEQ_BITS'(1);
    assign run_slot = slot_inc(r_last, r_slot);
    assign run_next = slot_inc(run_nx, run_slot);

    // slot of an init number: quotient estimate low by at most one
    assign mod_prod = (2*SEQ_BITS)'(r_last) * (2*SEQ_BITS)'(RECIP_C);
    assign mod_q    = mod_prod[2*SEQ_BITS-1:SEQ_BITS];
    assign mod_est  = CW'(r_last) - CW'(mod_q) * WIN_C;
    assign mod_rem  = (mod_est >= WIN_C) ? (mod_est - WIN_C) : mod_est;

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_armed   = r_armed;
        n_last    = r_last;
        n_slot    = r_slot;
        n_occ     = r_occ;
        n_cnt     = r_cnt;
        ram_we    = 1'b0;
        ram_raddr = run_slot;
        load_out  = 1'b0;
        o_kind    = K_RELEASED;
        o_seq     = SEQ_W'(sq);
        o_src     = r_in_src;
        o_pay     = r_in_pay;
        o_last    = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                    if (r_in_func) begin
                        o_kind  = K_INIT;
                        o_src   = '0;
                        o_pay   = '0;
                        n_armed = 1'b1;
                        n_last  = sq;
                        n_occ   = '0;
                        n_state = S_MOD;
                    end else if (!r_armed) begin
                        o_kind = K_NOT_ARMED;
                    end else if (d == SEQ_BITS'(1)) begin
                        o_kind    = K_RELEASED;
                        n_last    = sq;
                        n_slot    = ev_slot;
                        n_cnt     = CNTW'(1);
                        ram_raddr = ev_next;
                        if ((1 < MAX_RESULTS) && r_occ[ev_next]) begin
                            o_last  = 1'b0;
                            n_state = S_RUN;
                        end
                    end else if (in_win) begin
                        if (r_occ[ev_slot]) begin
                            o_kind = K_DUPLICATE;
                        end else begin
                            o_kind         = K_HELD;
                            n_occ[ev_slot] = 1'b1;
                            ram_we         = 1'b1;
                        end
                    end else if (recent) begin
                        o_kind = K_DUPLICATE;
                    end else begin
                        o_kind = K_BEYOND;
                    end
                end
            end
            S_RUN: begin
                if (out_free) begin
                    load_out        = 1'b1;
                    o_kind          = K_RELEASED;
                    o_seq           = SEQ_W'(run_nx);
                    o_src           = ram_rdata[STORE_W-1:PAY_W];
                    o_pay           = ram_rdata[PAY_W-1:0];
                    n_occ[run_slot] = 1'b0;
                    n_last          = run_nx;
                    n_slot          = run_slot;
                    n_cnt           = r_cnt + CNTW'(1);
                    ram_raddr       = run_next;
                    if ((n_cnt < CNTW'(MAX_RESULTS)) && r_occ[run_next]) begin
                        o_last = 1'b0;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_MOD: begin
                n_slot  = SB'(mod_rem);
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_armed <= 1'b0;
            r_last  <= SEQ_BITS'(1);
            r_slot  <= SB'(1);
            r_occ   <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_armed <= n_armed;
            r_last  <= n_last;
            r_slot  <= n_slot;
            r_occ   <= n_occ;
            r_cnt   <= n_cnt;
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // captured input beat and output register payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_func <= i_in.func;
            r_in_seq  <= i_in.seq;
            r_in_src  <= i_in.source_id;
            r_in_pay  <= i_in.payload_tag;
        end
        if (load_out) begin
            r_okind <= o_kind;
            r_oseq  <= o_seq;
            r_osrc  <= o_src;
            r_opay  <= o_pay;
            r_olast <= o_last;
        end
    end

    // held messages: source and payload handle per slot
    srb_ram #(
        .WIDTH (STORE_W),
        .DEPTH (WINDOW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ev_slot),
        .i_wdata ({r_in_src, r_in_pay}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out.valid       = r_ov;
    assign o_out.kind        = r_okind;
    assign o_out.out_seq     = r_oseq;
    assign o_out.out_source  = r_osrc;
    assign o_out.out_payload = r_opay;
    assign o_out.last        = r_olast;

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
    import srb_pkg::*;

    localparam int WIN            = DEF_WINDOW;
    localparam int N_RANDOM       = 255;
    localparam int N_CALM         = 40;
    localparam int WATCHDOG_LIMIT = 600;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct {
        logic             func;
        logic [SEQ_W-1:0] seq;
        logic [SRC_W-1:0] src;
        logic [PAY_W-1:0] pay;
    } t_msg;

    typedef struct {
        t_kind            kind;
        logic [SEQ_W-1:0] seq;
        logic [SRC_W-1:0] src;
        logic [PAY_W-1:0] pay;
        logic             last;
    } t_result;

    typedef struct {
        t_msg  msg;
        bit    typed;
        t_kind kind;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    srb_in_if  in_ch ();
    srb_out_if out_ch ();

    sequence_reorder_buffer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // shadow copy of the resequencer state
    logic [SEQ_W-1:0] pr_last;
    logic             pr_armed;
    logic             pr_held [WIN];
    logic [SRC_W-1:0] pr_src  [WIN];
    logic [PAY_W-1:0] pr_pay  [WIN];

    t_result due_results [$];
    t_result new_beats   [$];
    t_row    plan        [$];

    int  n_errors;
    int  n_sent;
    int  n_inits;
    int  n_checked;
    int  longest_run;
    int  kind_seen [6];
    int  quiet_left;
    int  idle_cycles;
    bit  calm;

    // clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic void push_beat(input t_kind kind, input logic [SEQ_W-1:0] seq,
                                      input logic [SRC_W-1:0] src,
                                      input logic [PAY_W-1:0] pay);
        t_result r;
        r.kind = kind;
        r.seq  = seq;
        r.src  = src;
        r.pay  = pay;
        r.last = 1'b0;
        new_beats.push_back(r);
    endfunction

    // work out the result beats of one accepted input beat
    function automatic void resequence(input t_msg m);
        logic [SEQ_W-1:0] delta;
        logic [SEQ_W-1:0] nx;
        int               slot;
        new_beats.delete();
        if (m.func) begin
            pr_last  = m.seq;
            pr_armed = 1'b1;
            for (int i = 0; i < WIN; i++) pr_held[i] = 1'b0;
            push_beat(K_INIT, m.seq, '0, '0);
        end else if (!pr_armed) begin
            push_beat(K_NOT_ARMED, m.seq, m.src, m.pay);
        end else begin
            delta = m.seq - pr_last;
            if (delta == 1) begin
                push_beat(K_RELEASED, m.seq, m.src, m.pay);
                pr_last = m.seq;
                // drain the run of held successors
                while (new_beats.size() < MAX_RESULTS) begin
                    nx   = pr_last + 1'b1;
                    slot = int'(nx) % WIN;
                    if (!pr_held[slot]) break;
                    push_beat(K_RELEASED, nx, pr_src[slot], pr_pay[slot]);
                    pr_held[slot] = 1'b0;
                    pr_last       = nx;
                end
                if (new_beats.size() > longest_run) longest_run = new_beats.size();
            end else if (delta >= 2 && int'(delta) <= WIN) begin
                slot = int'(m.seq) % WIN;
                if (pr_held[slot]) begin
                    push_beat(K_DUPLICATE, m.seq, m.src, m.pay);
                end else begin
                    pr_held[slot] = 1'b1;
                    pr_src[slot]  = m.src;
                    pr_pay[slot]  = m.pay;
                    push_beat(K_HELD, m.seq, m.src, m.pay);
                end
            end else if (delta == 0 || int'(delta) + WIN >= (1 << SEQ_W)) begin
                push_beat(K_DUPLICATE, m.seq, m.src, m.pay);
            end else begin
                push_beat(K_BEYOND, m.seq, m.src, m.pay);
            end
        end
        new_beats[new_beats.size()-1].last = 1'b1;
    endfunction

    function automatic void add_row(input bit func, input logic [SEQ_W-1:0] seq,
                                    input logic [SRC_W-1:0] src,
                                    input logic [PAY_W-1:0] pay,
                                    input bit typed, input t_kind kind);
        t_row r;
        r.msg.func = func;
        r.msg.seq  = seq;
        r.msg.src  = src;
        r.msg.pay  = pay;
        r.typed    = typed;
        r.kind     = kind;
        plan.push_back(r);
    endfunction

    // drive one input beat, wait for it to be taken, then queue its results
    task automatic send(input t_msg m, input bit typed, input t_kind kind);
        t_result r;
        int      gap;
        if (quiet_left > 0) begin
            quiet_left--;
        end else if (!calm) begin
            case ($urandom_range(0, 7))
                0, 1: begin
                    gap = $urandom_range(1, 17);
                    in_ch.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                2: begin
                    quiet_left = $urandom_range(8, 30);
                end
                default: begin
                end
            endcase
        end
        in_ch.valid       <= 1'b1;
        in_ch.func        <= m.func;
        in_ch.seq         <= m.seq;
        in_ch.source_id   <= m.src;
        in_ch.payload_tag <= m.pay;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        resequence(m);
        if (typed) begin
            r.kind = kind;
            r.seq  = m.seq;
            r.src  = m.func ? '0 : m.src;
            r.pay  = m.func ? '0 : m.pay;
            r.last = 1'b1;
            due_results.push_back(r);
        end else begin
            foreach (new_beats[i]) due_results.push_back(new_beats[i]);
        end
        n_sent++;
        if (m.func) n_inits++;
    endtask

    // stray message: recently delivered, far ahead, in window or anywhere
    task automatic send_noise();
        t_msg m;
        m.func = 1'b0;
        m.src  = SRC_W'($urandom_range(0, 127));
        m.pay  = PAY_W'($urandom_range(0, 65535));
        case ($urandom_range(0, 3))
            0:       m.seq = SEQ_W'($urandom_range(0, 255));
            1:       m.seq = SEQ_W'(pr_last - $urandom_range(0, WIN));
            2:       m.seq = SEQ_W'(pr_last + $urandom_range(WIN + 1, 255 - WIN));
            default: m.seq = SEQ_W'(pr_last + $urandom_range(2, WIN));
        endcase
        send(m, 1'b0, K_RELEASED);
    endtask

    // up to a window's worth of consecutive messages in shuffled order
    task automatic run_episode();
        logic [SEQ_W-1:0] base;
        int               span;
        int               j;
        int               tmp;
        int               offs [$];
        t_msg             m;
        if ($urandom_range(0, 2) == 0) begin
            m.func = 1'b1;
            m.seq  = SEQ_W'($urandom_range(0, 255));
            m.src  = SRC_W'($urandom_range(0, 127));
            m.pay  = PAY_W'($urandom_range(0, 65535));
            send(m, 1'b0, K_INIT);
        end
        base = pr_last;
        span = ($urandom_range(0, 3) == 0) ? WIN : $urandom_range(1, WIN);
        for (int k = 2; k <= span; k++) offs.push_back(k);
        for (int k = offs.size() - 1; k > 0; k--) begin
            j       = $urandom_range(0, k);
            tmp     = offs[k];
            offs[k] = offs[j];
            offs[j] = tmp;
        end
        // a full window releases everything in one run when the next one comes last
        if (span == WIN || $urandom_range(0, 1) == 1) offs.push_back(1);
        else offs.insert($urandom_range(0, offs.size()), 1);
        // broken sequence: one message never arrives
        if (offs.size() > 1 && $urandom_range(0, 5) == 0)
            offs.delete($urandom_range(0, offs.size() - 1));
        foreach (offs[k]) begin
            if ($urandom_range(0, 7) == 0) send_noise();
            m.func = 1'b0;
            m.seq  = SEQ_W'(base + offs[k]);
            m.src  = SRC_W'($urandom_range(0, 127));
            m.pay  = PAY_W'($urandom_range(0, 65535));
            send(m, 1'b0, K_RELEASED);
        end
    endtask

    // receiver side: bursts of stall between runs of ready
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 2) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    end

    // result checking and watchdog
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                         $realtime, idle_cycles, due_results.size());
                $display("RESULT: ERROR");
                $finish;
            end
            if (out_ch.valid && out_ch.ready) begin
                n_checked++;
                if (out_ch.kind < 6) kind_seen[out_ch.kind]++;
                if (due_results.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected beat kind %0d seq %02h src %02h pay %04h last %0b",
                             $realtime, out_ch.kind, out_ch.out_seq, out_ch.out_source,
                             out_ch.out_payload, out_ch.last);
                end else begin
                    want = due_results.pop_front();
                    if (out_ch.kind !== want.kind || out_ch.out_seq !== want.seq ||
                        out_ch.out_source !== want.src || out_ch.out_payload !== want.pay ||
                        out_ch.last !== want.last) begin
                        n_errors++;
                        $display("%0t: mismatch, expected kind %0d seq %02h src %02h pay %04h last %0b",
                                 $realtime, want.kind, want.seq, want.src, want.pay, want.last);
                        $display("%0t:           actual kind %0d seq %02h src %02h pay %04h last %0b",
                                 $realtime, out_ch.kind, out_ch.out_seq, out_ch.out_source,
                                 out_ch.out_payload, out_ch.last);
                    end
                end
            end
        end
    end

    // reset, directed table, random episodes, drain
    initial begin
        t_msg m;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.func        <= 1'b0;
        in_ch.seq         <= '0;
        in_ch.source_id   <= '0;
        in_ch.payload_tag <= '0;
        pr_last     = 8'd1;
        pr_armed    = 1'b0;
        for (int i = 0; i < WIN; i++) pr_held[i] = 1'b0;
        n_errors    = 0;
        n_sent      = 0;
        n_inits     = 0;
        n_checked   = 0;
        longest_run = 0;
        quiet_left  = 0;
        idle_cycles = 0;
        calm        = 1'b0;
        foreach (kind_seen[i]) kind_seen[i] = 0;

        // not armed after reset, field extremes
        add_row(1'b0, 8'h00, 7'h00, 16'h0000, 1'b1, K_NOT_ARMED);
        add_row(1'b0, 8'hFF, 7'h7F, 16'hFFFF, 1'b1, K_NOT_ARMED);
        // arm just below the wrap, init echoes no source or payload
        add_row(1'b1, 8'hFE, 7'h7F, 16'hFFFF, 1'b1, K_INIT);
        add_row(1'b0, 8'h01, 7'h12, 16'h1234, 1'b1, K_HELD);
        add_row(1'b0, 8'h00, 7'h00, 16'h0000, 1'b1, K_HELD);
        // occupied slot in window
        add_row(1'b0, 8'h00, 7'h7F, 16'hFFFF, 1'b1, K_DUPLICATE);
        // far edge of the window, then one past it
        add_row(1'b0, 8'h0E, 7'h7F, 16'hFFFF, 1'b1, K_HELD);
        add_row(1'b0, 8'h0F, 7'h40, 16'h8000, 1'b1, K_BEYOND);
        // last delivered itself and the recently delivered band
        add_row(1'b0, 8'hFE, 7'h01, 16'h0001, 1'b1, K_DUPLICATE);
        add_row(1'b0, 8'hEF, 7'h3C, 16'h0F0F, 1'b1, K_DUPLICATE);
        add_row(1'b0, 8'hEE, 7'h66, 16'hF0F0, 1'b1, K_DUPLICATE);
        add_row(1'b0, 8'hED, 7'h19, 16'h7FFF, 1'b1, K_BEYOND);
        // next expected across the wrap releases a run of three
        add_row(1'b0, 8'hFF, 7'h01, 16'h0001, 1'b0, K_RELEASED);
        add_row(1'b0, 8'h11, 7'h33, 16'hC3C3, 1'b1, K_HELD);
        // init while armed clears every held slot
        add_row(1'b1, 8'h80, 7'h00, 16'h0000, 1'b1, K_INIT);
        add_row(1'b0, 8'h82, 7'h55, 16'hAAAA, 1'b1, K_HELD);
        add_row(1'b0, 8'h81, 7'h2A, 16'h5555, 1'b0, K_RELEASED);
        add_row(1'b0, 8'h8E, 7'h0F, 16'h00FF, 1'b1, K_HELD);
        add_row(1'b1, 8'h00, 7'h7F, 16'hFFFF, 1'b1, K_INIT);
        add_row(1'b0, 8'h01, 7'h70, 16'hFF00, 1'b1, K_RELEASED);
        add_row(1'b1, 8'hFF, 7'h7F, 16'hFFFF, 1'b1, K_INIT);
        add_row(1'b0, 8'h00, 7'h7F, 16'hFFFF, 1'b1, K_RELEASED);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) send(plan[i].msg, plan[i].typed, plan[i].kind);

        while (n_sent < plan.size() + N_RANDOM) begin
            if (n_sent >= plan.size() + N_RANDOM - N_CALM) calm = 1'b1;
            run_episode();
        end

        in_ch.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d input beats (%0d inits), %0d result beats checked",
                 n_sent, n_inits, n_checked);
        $display("released %0d, held %0d, duplicate %0d, beyond %0d, longest run %0d",
                 kind_seen[K_RELEASED], kind_seen[K_HELD], kind_seen[K_DUPLICATE],
                 kind_seen[K_BEYOND], longest_run);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/srb_pkg.sv
rtl/core/srb_if.sv
rtl/core/srb_ram.sv
rtl/core/sequence_reorder_buffer.sv
sim/tb.sv
